>>> src/rnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling nucleotide decoder package
// Shared constants, the permutation table and lookup helpers for the decoder.
// ----------------------------------------------------------------------------
package rnd_pkg;

    localparam int unsigned TableSize = 24;
    localparam logic [4:0]  RollStep  = 5'd6;
    localparam logic [4:0]  ByteStep  = 5'd7;
    localparam logic [15:0] JunkMax   = 16'hFFFF;
    localparam logic [3:0]  LimitReset = 4'd3;

    // Slot value returned for an absent base.
    localparam logic [2:0] SlotNone = 3'd4;

    // One entry per permutation, first letter in the top byte.
    localparam logic [31:0] PermTable [TableSize] = '{
        32'h41434754, 32'h41435447, 32'h41474354, 32'h41475443,
        32'h41544347, 32'h41544743, 32'h43415447, 32'h43414754,
        32'h43475441, 32'h43474154, 32'h43544741, 32'h43544147,
        32'h47414354, 32'h47415443, 32'h47434154, 32'h47435441,
        32'h47544143, 32'h47544341, 32'h54414743, 32'h54414347,
        32'h54434741, 32'h54434147, 32'h54474341, 32'h54474143
    };

    // Result of one data byte as it leaves the core.
    typedef struct packed {
        logic [15:0] junk_total;
        logic [7:0]  data_byte;
    } rnd_result_t;

    // Position of a base inside the entry at pos, SlotNone when absent.
    function automatic logic [2:0] find_slot(input logic [4:0] pos,
                                             input logic [7:0] base);
        logic [31:0] entry;
        logic [2:0]  slot;
        entry = (pos < 5'(TableSize)) ? PermTable[pos] : '0;
        slot  = SlotNone;
        for (int s = 3; s >= 0; s--) begin
            if (entry[8*(3-s) +: 8] == base) begin
                slot = 3'(s);
            end
        end
        return slot;
    endfunction

    // Extra roll chosen by where the base sits in the new entry.
    function automatic logic [2:0] advance_for_slot(input logic [1:0] slot);
        logic [2:0] adv;
        unique case (slot)
            2'd0:    adv = 3'd6;
            2'd1:    adv = 3'd2;
            2'd2:    adv = 3'd1;
            default: adv = 3'd3;
        endcase
        return adv;
    endfunction

    // Reduce a sum of two positions below the table size.
    function automatic logic [4:0] wrap24(input logic [4:0] v);
        return (v >= 5'(TableSize)) ? 5'(v - 5'(TableSize)) : v;
    endfunction

endpackage

>>> src/rnd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted nucleotide beat until the core consumes it.
// ----------------------------------------------------------------------------
module rnd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       valid,
    output logic [7:0] base
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] base_reg;
    logic       load;

    // The register is free when empty or when its beat leaves this cycle.
    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            base_reg <= s_tdata;
        end
    end

    assign valid = valid_reg;
    assign base  = base_reg;

endmodule

>>> src/rnd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder core
// Holds the rolling table state and decodes one base per step.
// ----------------------------------------------------------------------------
module rnd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               step,
    input  logic [7:0]         base,
    output logic               emit,
    output rnd_pkg::rnd_result_t result
);

    logic [3:0]  limit_reg;
    logic [4:0]  pos_reg,   pos_next;
    logic [2:0]  adv_reg,   adv_next;
    logic [7:0]  prev_reg;
    logic [3:0]  run_reg,   run_next;
    logic [1:0]  slot_reg,  slot_next;
    logic [7:0]  acc_reg,   acc_next;
    logic [4:0]  bidx_reg,  bidx_next;
    logic [15:0] junk_reg,  junk_next;

    logic        is_junk;
    logic [3:0]  run_data;
    logic [2:0]  cur_slot;
    logic [1:0]  code;
    logic [7:0]  acc_new;
    logic        do_roll;
    logic [4:0]  pos_rolled6;
    logic [2:0]  roll_slot;
    logic [2:0]  adv_roll;
    logic [4:0]  pos_roll;
    logic [4:0]  pos_after;

    // A run that already meets the limit turns this base into junk.
    assign is_junk  = run_reg >= limit_reg;
    assign run_data = (prev_reg == base) ? 4'(run_reg + 4'd1) : 4'd1;

    // Decode against the current entry; an unknown letter reads as zero.
    assign cur_slot = rnd_pkg::find_slot(pos_reg, base);
    assign code     = cur_slot[2] ? 2'd0 : cur_slot[1:0];
    assign acc_new  = acc_reg | (8'(code) << {~slot_reg, 1'b0});

    // Roll: step by six, then by the amount the base picks in the new entry.
    assign do_roll     = is_junk || (run_data < limit_reg);
    assign pos_rolled6 = rnd_pkg::wrap24(5'(pos_reg + rnd_pkg::RollStep));
    assign roll_slot   = rnd_pkg::find_slot(pos_rolled6, base);
    assign adv_roll    = roll_slot[2] ? adv_reg : rnd_pkg::advance_for_slot(roll_slot[1:0]);
    assign pos_roll    = rnd_pkg::wrap24(5'(pos_rolled6 + 5'(adv_roll)));
    assign pos_after   = do_roll ? pos_roll : pos_reg;

    // A byte completes on the fourth data base.
    assign emit = !is_junk && (slot_reg == 2'd3);

    always_comb begin
        pos_next  = pos_after;
        if (emit && (bidx_reg != 5'd0)) begin
            pos_next = rnd_pkg::wrap24(5'(pos_after + rnd_pkg::ByteStep));
        end
        adv_next  = do_roll ? adv_roll : adv_reg;
        run_next  = is_junk ? 4'd1 : run_data;
        slot_next = is_junk ? slot_reg : 2'(slot_reg + 2'd1);
        acc_next  = (is_junk) ? acc_reg : (emit ? 8'd0 : acc_new);
        bidx_next = emit ? rnd_pkg::wrap24(5'(bidx_reg + 5'd1)) : bidx_reg;
        junk_next = (is_junk && (junk_reg != rnd_pkg::JunkMax)) ?
                    16'(junk_reg + 16'd1) : junk_reg;
    end

    // State registers update only when a base is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= rnd_pkg::LimitReset;
            pos_reg   <= '0;
            adv_reg   <= '0;
            prev_reg  <= '0;
            run_reg   <= 4'd1;
            slot_reg  <= '0;
            acc_reg   <= '0;
            bidx_reg  <= '0;
            junk_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (step) begin
                pos_reg  <= pos_next;
                adv_reg  <= adv_next;
                prev_reg <= base;
                run_reg  <= run_next;
                slot_reg <= slot_next;
                acc_reg  <= acc_next;
                bidx_reg <= bidx_next;
                junk_reg <= junk_next;
            end
        end
    end

    assign result.data_byte  = acc_new;
    assign result.junk_total = junk_reg;

endmodule

>>> src/rnd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output register
// Holds one decoded byte beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module rnd_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  rnd_pkg::rnd_result_t result,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata
);

    logic                 valid_reg;
    logic                 valid_next;
    rnd_pkg::rnd_result_t data_reg;

    // Free when empty or when the held beat is taken this cycle.
    assign free       = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> src/rolling_nucleotide_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling nucleotide decoder
// Decodes ASCII bases two bits at a time through a rolling permutation table.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] nucleotide
//  m_*       out        tdata[7:0] data_byte, tdata[23:8] junk_total
//  cfg_*     in         cfg_wr_data[3:0] homopolymer_limit
//
// One base per cycle sustained while the output register can take each finished
// byte; an accepted beat is held in the input register and decoded from there,
// and when it is consumed a finished byte loads the output register, which drives m_tvalid.
// The rolling table state is a registered feedback loop in the core.
// Reset is synchronous and active low; both registers empty on reset.
// A full output register stalls only bases that complete a byte.
// ----------------------------------------------------------------------------
module rolling_nucleotide_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // homopolymer_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] nucleotide
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // [7:0] data_byte, [23:8] junk_total
);

    logic                 in_valid;
    logic [7:0]           in_base;
    logic                 take;
    logic                 emit;
    logic                 out_free;
    rnd_pkg::rnd_result_t result;

    // Consume a base unless it makes a byte and the output is still full.
    assign take = in_valid && (!emit || out_free);

    rnd_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .valid    (in_valid),
        .base     (in_base)
    );

    rnd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .base        (in_base),
        .emit        (emit),
        .result      (result)
    );

    rnd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> src/rnd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the top-level ports for stall, reset and junk count behavior.
// ----------------------------------------------------------------------------
module rnd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [15:0] last_junk_reg;
    logic        seen_reg;

    // Junk count of the most recent output beat since reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            last_junk_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            seen_reg      <= 1'b1;
            last_junk_reg <= m_tdata[23:8];
        end
    end

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Reset empties the input register, so a base is taken at once.
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // The junk count never goes down between bytes.
    a_junk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && seen_reg |-> m_tdata[23:8] >= last_junk_reg)
        else $error("junk count decreased");

endmodule

bind rolling_nucleotide_decoder_top rnd_checker u_rnd_checker (.*);
